FILE: rtl/core/fc32_pkg.sv
// ----------------------------------------------------------------------------
// fc32_pkg
// Constants and round functions for the 32-bit Feistel encryption core.
// ----------------------------------------------------------------------------
package fc32_pkg;

  // Key bits are indexed MSB-first: index 0 is bit 63 of the master key.
  typedef logic [0:63] key_bits_t;
  typedef logic [7:0]  byte_t;
  typedef logic [5:0]  bit_idx_t;

  localparam bit_idx_t PERM [64] = '{
    6'd48, 6'd49, 6'd50, 6'd51, 6'd52, 6'd53, 6'd54, 6'd55,
    6'd56, 6'd57, 6'd58, 6'd59, 6'd60, 6'd61, 6'd62, 6'd63,
    6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,  6'd10, 6'd11,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd20, 6'd21, 6'd22, 6'd23,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31,
    6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
    6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47,
    6'd0,  6'd1,  6'd2,  6'd3,  6'd16, 6'd17, 6'd18, 6'd19
  };

  localparam bit_idx_t SEL0 [8] = '{6'd0,  6'd1,  6'd2,  6'd3,  6'd8,  6'd9,  6'd10, 6'd11};
  localparam bit_idx_t SEL1 [8] = '{6'd4,  6'd5,  6'd6,  6'd7,  6'd12, 6'd13, 6'd14, 6'd15};
  localparam bit_idx_t SEL2 [8] = '{6'd16, 6'd17, 6'd18, 6'd19, 6'd24, 6'd25, 6'd26, 6'd27};
  localparam bit_idx_t SEL3 [8] = '{6'd20, 6'd21, 6'd22, 6'd23, 6'd28, 6'd29, 6'd30, 6'd31};

  function automatic byte_t ffun(input byte_t x);
    byte_t r1, r2, r7;
    r1 = {x[6:0], x[7]};
    r2 = {x[5:0], x[7:6]};
    r7 = {x[0], x[7:1]};
    return (r1 & r7) ^ r2;
  endfunction

  // Round constant is all zero, so only the NX mix and the permutation remain.
  function automatic key_bits_t key_update(input key_bits_t kb);
    key_bits_t nx;
    key_bits_t nk;
    nx = kb;
    nx[56] = kb[56] & (kb[56] ^ kb[62]);
    nx[57] = kb[57] & (kb[57] ^ kb[63]);
    nx[58] = kb[58] & (kb[58] ^ kb[56] ^ kb[62]);
    nx[59] = kb[59] & (kb[59] ^ kb[57] ^ kb[63]);
    nx[60] = kb[60] & (kb[60] ^ kb[58] ^ kb[56] ^ kb[62]);
    nx[61] = kb[61] & (kb[61] ^ kb[59] ^ kb[57] ^ kb[63]);
    nx[62] = kb[62] & (kb[62] ^ kb[60] ^ kb[58] ^ kb[56] ^ kb[62]);
    nx[63] = kb[63] & (kb[63] ^ kb[61] ^ kb[59] ^ kb[57] ^ kb[63]);
    for (int i = 0; i < 64; i++) begin
      nk[i] = nx[PERM[i]];
    end
    return nk;
  endfunction

  function automatic byte_t pick_byte(input key_bits_t kb, input bit_idx_t sel [8]);
    byte_t v;
    for (int j = 0; j < 8; j++) begin
      v[7-j] = kb[sel[j]];
    end
    return v;
  endfunction

endpackage

FILE: rtl/core/feistel_cipher_32bit_encrypt.sv
// ----------------------------------------------------------------------------
// feistel_cipher_32bit_encrypt
// Fully unrolled round pipeline encrypting one 32-bit block per cycle.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   input    | start, busy               | left0_i right0_i left1_i right1_i
//   result   | out_valid_o (strobe)      | cipher_left0_o .. cipher_right1_o
//   config   | cfg_valid_i, cfg_ready_o  | cfg_wdata_i (master key)
//
// One round per register stage, the key schedule travels with each word.
// A new word is taken every cycle.
// busy is never raised and the pipeline never stalls, since results are
// only strobed. Reset clears the stage valid bits and the master key.
// ----------------------------------------------------------------------------
module feistel_cipher_32bit_encrypt
  import fc32_pkg::*;
#(
  parameter int ROUNDS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  left0_i,
  input  logic [7:0]  right0_i,
  input  logic [7:0]  left1_i,
  input  logic [7:0]  right1_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_wdata_i,
  output logic        out_valid_o,
  output logic [7:0]  cipher_left0_o,
  output logic [7:0]  cipher_right0_o,
  output logic [7:0]  cipher_left1_o,
  output logic [7:0]  cipher_right1_o
);

  logic [63:0] master_key_q;

  logic      vld_q [ROUNDS];
  byte_t     l0_q  [ROUNDS];
  byte_t     r0_q  [ROUNDS];
  byte_t     l1_q  [ROUNDS];
  byte_t     r1_q  [ROUNDS];
  key_bits_t key_q [ROUNDS];

  logic      s_vld [ROUNDS+1];
  byte_t     s_l0  [ROUNDS+1];
  byte_t     s_r0  [ROUNDS+1];
  byte_t     s_l1  [ROUNDS+1];
  byte_t     s_r1  [ROUNDS+1];
  key_bits_t s_key [ROUNDS+1];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_key_q <= '0;
    end else if (cfg_valid_i) begin
      master_key_q <= cfg_wdata_i;
    end
  end

  assign s_vld[0] = start;
  assign s_l0[0]  = left0_i;
  assign s_r0[0]  = right0_i;
  assign s_l1[0]  = left1_i;
  assign s_r1[0]  = right1_i;
  assign s_key[0] = master_key_q;

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    key_bits_t key_d;
    byte_t     k0, k1, k2, k3;
    byte_t     l0_d, r0_d, l1_d, r1_d;
    byte_t     t0, t1;

    always_comb begin
      key_d = key_update(s_key[g]);
      k0    = pick_byte(key_d, SEL0);
      k1    = pick_byte(key_d, SEL1);
      k2    = pick_byte(key_d, SEL2);
      k3    = pick_byte(key_d, SEL3);
      t0    = ffun(s_l0[g]) ^ s_r0[g] ^ k0;
      t1    = ffun(s_l1[g]) ^ s_r1[g] ^ k1;
      r0_d  = ffun(t0) ^ s_l0[g] ^ k2;
      r1_d  = ffun(t1) ^ s_l1[g] ^ k3;
      // left halves swap branches
      l0_d  = t1;
      l1_d  = t0;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= s_vld[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (s_vld[g]) begin
        l0_q[g]  <= l0_d;
        r0_q[g]  <= r0_d;
        l1_q[g]  <= l1_d;
        r1_q[g]  <= r1_d;
        key_q[g] <= key_d;
      end
    end

    assign s_vld[g+1] = vld_q[g];
    assign s_l0[g+1]  = l0_q[g];
    assign s_r0[g+1]  = r0_q[g];
    assign s_l1[g+1]  = l1_q[g];
    assign s_r1[g+1]  = r1_q[g];
    assign s_key[g+1] = key_q[g];
  end

  assign out_valid_o     = s_vld[ROUNDS];
  assign cipher_left0_o  = s_l0[ROUNDS];
  assign cipher_right0_o = s_r0[ROUNDS];
  assign cipher_left1_o  = s_l1[ROUNDS];
  assign cipher_right1_o = s_r1[ROUNDS];

endmodule
